/* design/histogram_binner_defines.svh */
// assertion macros for the histogram binner checker
`ifndef HISTOGRAM_BINNER_DEFINES_SVH
`define HISTOGRAM_BINNER_DEFINES_SVH

// clocked assertion, off while reset is high
`define HB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define HB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/hb_pkg.sv */
// shared types and constants of the histogram binner
package hb_pkg;

  localparam int VALUE_W     = 32;
  localparam int SLOT_W      = 7;
  localparam int FUNC_W      = 2;
  localparam int BIN_OUT_W   = 6;
  localparam int COUNT_OUT_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int BINS_W      = 7;
  localparam int WIDTH_W     = 31;
  localparam int DIV_STEPS   = 32;

  localparam logic [FUNC_W-1:0] FUNC_TALLY = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SPACING_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_EDGE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_EDGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH    = 3'd4;

  localparam logic                      RST_SPACING_MODE = 1'b0;
  localparam logic [BINS_W-1:0]         RST_BINS_IN_USE  = 7'd64;
  localparam logic signed [VALUE_W-1:0] RST_FIRST_EDGE   = 32'sd0;
  localparam logic signed [VALUE_W-1:0] RST_LAST_EDGE    = 32'sd4194304;
  localparam logic [WIDTH_W-1:0]        RST_BIN_WIDTH    = 31'd65536;

  typedef enum logic [1:0] {
    EA_LAST,
    EA_ZERO,
    EA_NEXT,
    EA_NEXT2
  } edge_sel_t;

  typedef enum logic [1:0] {
    BS_LAST,
    BS_QUO,
    BS_SCAN
  } bin_src_t;

  typedef enum logic [1:0] {
    RK_MISS,
    RK_SLOT,
    RK_READ,
    RK_COUNT
  } res_kind_t;

  typedef struct packed {
    logic      load_item;
    logic      clr_wr;
    logic      div_start;
    logic      div_step;
    logic      edge_rd;
    edge_sel_t edge_sel;
    logic      edge_wr;
    logic      prev_load;
    logic      scan_clr;
    logic      scan_inc;
    logic      bin_set;
    bin_src_t  bin_src;
    logic      cnt_rd;
    logic      cnt_rd_slot;
    logic      cnt_wr;
    logic      res_set;
    res_kind_t res_kind;
    logic      out_load;
  } hb_cmd_t;

  typedef struct packed {
    logic              clr_last;
    logic [FUNC_W-1:0] func;
    logic              mode;
    logic              lin_hit_last;
    logic              lin_out;
    logic              div_last;
    logic              q_ok;
    logic              edge_hit_last;
    logic              edge_match;
    logic              scan_last;
  } hb_status_t;

endpackage

/* design/hb_item_if.sv */
// input item channel
interface hb_item_if import hb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;
  logic [SLOT_W-1:0]         slot;

  modport source (output valid, output func, output value, output slot, input ready);
  modport sink (input valid, input func, input value, input slot, output ready);
  modport monitor (input valid, input ready, input func, input value, input slot);
endinterface

/* design/hb_result_if.sv */
// result channel
interface hb_result_if import hb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [BIN_OUT_W-1:0]   bin_found;
  logic                   in_range;
  logic [COUNT_OUT_W-1:0] count;

  modport source (output valid, output bin_found, output in_range, output count, input ready);
  modport sink (input valid, input bin_found, input in_range, input count, output ready);
  modport monitor (input valid, input ready, input bin_found, input in_range, input count);
endinterface

/* design/hb_cfg_if.sv */
// configuration write channel
interface hb_cfg_if import hb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/histogram_binner.sv */
// top level of the histogram binner
// Histogram engine on signed Q16.16 samples with saturating bin counters.
// One word is worked on at a time; the next word is taken while the last
// result still waits on the result channel. A linear-mode tally of an
// in-range word below the last edge gets its bin from the 32-step
// shift-subtract divider. An edge-table tally compares the last edge,
// then scans the n bins in use, reading one edge per cycle from the
// edge table's single read port. After reset a clearing pass zeroes the
// counter memory, one counter per cycle; no word is taken meanwhile, but
// configuration writes are. Edges must be loaded before edge-table use.
module histogram_binner import hb_pkg::*; #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  hb_item_if.sink     item,
  hb_result_if.source result,
  hb_cfg_if.sink      cfg
);

  hb_cmd_t    cmd;
  hb_status_t st;

  hb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .st           (st),
    .cmd          (cmd)
  );

  hb_datapath #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .st         (st),
    .item_func  (item.func),
    .item_value (item.value),
    .item_slot  (item.slot),
    .bin_found  (result.bin_found),
    .in_range   (result.in_range),
    .count      (result.count)
  );

endmodule

/* design/hb_ctrl.sv */
// controller state machine of the histogram binner
module hb_ctrl import hb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic       result_ready,
  output logic       result_valid,
  input  hb_status_t st,
  output hb_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_LIN_DIV,
    S_LIN_END,
    S_EDGE_LAST_CMP,
    S_EDGE_PRIME,
    S_EDGE_SCAN,
    S_CNT_RD,
    S_CNT_WR,
    S_READ_RES,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.func)
          FUNC_TALLY: begin
            if (st.mode) begin
              cmd.edge_rd = 1'b1;
              cmd.edge_sel = EA_LAST;
              state_next = S_EDGE_LAST_CMP;
            end else if (st.lin_hit_last) begin
              cmd.bin_set = 1'b1;
              cmd.bin_src = BS_LAST;
              state_next = S_CNT_RD;
            end else if (st.lin_out) begin
              cmd.res_set = 1'b1;
              cmd.res_kind = RK_MISS;
              state_next = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_next = S_LIN_DIV;
            end
          end
          FUNC_LOAD: begin
            cmd.edge_wr = 1'b1;
            cmd.res_set = 1'b1;
            cmd.res_kind = RK_SLOT;
            state_next = S_DONE;
          end
          FUNC_READ: begin
            cmd.cnt_rd = 1'b1;
            cmd.cnt_rd_slot = 1'b1;
            state_next = S_READ_RES;
          end
          default: begin
            cmd.res_set = 1'b1;
            cmd.res_kind = RK_MISS;
            state_next = S_DONE;
          end
        endcase
      end
      S_LIN_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_LIN_END;
      end
      S_LIN_END: begin
        if (st.q_ok) begin
          cmd.bin_set = 1'b1;
          cmd.bin_src = BS_QUO;
          state_next = S_CNT_RD;
        end else begin
          cmd.res_set = 1'b1;
          cmd.res_kind = RK_MISS;
          state_next = S_DONE;
        end
      end
      S_EDGE_LAST_CMP: begin
        if (st.edge_hit_last) begin
          cmd.bin_set = 1'b1;
          cmd.bin_src = BS_LAST;
          state_next = S_CNT_RD;
        end else begin
          cmd.edge_rd = 1'b1;
          cmd.edge_sel = EA_ZERO;
          cmd.scan_clr = 1'b1;
          state_next = S_EDGE_PRIME;
        end
      end
      S_EDGE_PRIME: begin
        cmd.prev_load = 1'b1;
        cmd.edge_rd = 1'b1;
        cmd.edge_sel = EA_NEXT;
        state_next = S_EDGE_SCAN;
      end
      S_EDGE_SCAN: begin
        if (st.edge_match) begin
          cmd.bin_set = 1'b1;
          cmd.bin_src = BS_SCAN;
          state_next = S_CNT_RD;
        end else if (st.scan_last) begin
          cmd.res_set = 1'b1;
          cmd.res_kind = RK_MISS;
          state_next = S_DONE;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.edge_rd = 1'b1;
          cmd.edge_sel = EA_NEXT2;
          cmd.scan_inc = 1'b1;
        end
      end
      S_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_next = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        cmd.res_set = 1'b1;
        cmd.res_kind = RK_COUNT;
        state_next = S_DONE;
      end
      S_READ_RES: begin
        cmd.res_set = 1'b1;
        cmd.res_kind = RK_READ;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

/* design/hb_datapath.sv */
// datapath: config registers, divider, edge table, counter memory, result word
module hb_datapath import hb_pkg::*; #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  hb_cfg_if.sink                    cfg,
  input  hb_cmd_t                   cmd,
  output hb_status_t                st,
  input  logic [FUNC_W-1:0]         item_func,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic [SLOT_W-1:0]         item_slot,
  output logic [BIN_OUT_W-1:0]      bin_found,
  output logic                      in_range,
  output logic [COUNT_OUT_W-1:0]    count
);

  localparam int EW  = $clog2(MAX_BINS + 1);
  localparam int BW  = $clog2(MAX_BINS);
  localparam int NCW = (EW > SLOT_W) ? EW : SLOT_W;
  localparam int DCW = $clog2(DIV_STEPS);

  logic                      spacing_mode;
  logic [BINS_W-1:0]         bins_in_use;
  logic signed [VALUE_W-1:0] first_edge;
  logic signed [VALUE_W-1:0] last_edge;
  logic [WIDTH_W-1:0]        bin_width;

  logic [FUNC_W-1:0]         func_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [SLOT_W-1:0]         slot_q;

  logic [NCW-1:0] bins_ext;
  logic [NCW-1:0] max_ext;
  logic [NCW-1:0] slot_ext;
  logic [EW-1:0]  n;

  logic [VALUE_W-1:0] offset;
  logic [WIDTH_W-1:0] w;
  logic [WIDTH_W-1:0] rem;
  logic [VALUE_W-1:0] quo;
  logic [DCW-1:0]     div_cnt;
  logic [VALUE_W-1:0] shifted;
  logic [VALUE_W:0]   trial;

  logic signed [VALUE_W-1:0] edge_mem [MAX_BINS + 1];
  logic signed [VALUE_W-1:0] edge_q;
  logic signed [VALUE_W-1:0] prev;
  logic [EW-1:0]             scan_i;
  logic [EW-1:0]             edge_addr;

  logic [COUNT_BITS-1:0] cnt_mem [MAX_BINS];
  logic [COUNT_BITS-1:0] cnt_q;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [BW-1:0]         bin;
  logic [BW-1:0]         clr_addr;
  logic [BW-1:0]         cnt_addr;

  logic [BIN_OUT_W-1:0]   res_bin;
  logic                   res_in;
  logic [COUNT_OUT_W-1:0] res_cnt;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_mode <= RST_SPACING_MODE;
      bins_in_use <= RST_BINS_IN_USE;
      first_edge <= RST_FIRST_EDGE;
      last_edge <= RST_LAST_EDGE;
      bin_width <= RST_BIN_WIDTH;
      clr_addr <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SPACING_MODE: spacing_mode <= cfg.data[0];
          REG_BINS_IN_USE:  bins_in_use <= cfg.data[BINS_W-1:0];
          REG_FIRST_EDGE:   first_edge <= cfg.data;
          REG_LAST_EDGE:    last_edge <= cfg.data;
          REG_BIN_WIDTH:    bin_width <= cfg.data[WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_wr) clr_addr <= clr_addr + BW'(1);
    end
  end

  // active bin count, clamped to 1..MAX_BINS
  assign bins_ext = NCW'(bins_in_use);
  assign max_ext  = NCW'(MAX_BINS);
  assign slot_ext = NCW'(slot_q);

  always_comb begin
    if (bins_ext == '0) n = EW'(1);
    else if (bins_ext > max_ext) n = EW'(MAX_BINS);
    else n = EW'(bins_ext);
  end

  // linear mode divider, one quotient bit per cycle
  assign offset  = value_q - first_edge;
  assign w       = (bin_width == '0) ? WIDTH_W'(1) : bin_width;
  assign shifted = {rem, quo[VALUE_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, w};

  always_comb begin
    case (cmd.edge_sel)
      EA_LAST:  edge_addr = n;
      EA_ZERO:  edge_addr = '0;
      EA_NEXT:  edge_addr = scan_i + EW'(1);
      EA_NEXT2: edge_addr = scan_i + EW'(2);
      default:  edge_addr = '0;
    endcase
  end

  assign cnt_addr = cmd.cnt_rd_slot ? BW'(slot_q) : bin;
  assign cnt_new  = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_q <= item_func;
      value_q <= item_value;
      slot_q <= item_slot;
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= offset;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[VALUE_W]) begin
        rem <= trial[WIDTH_W-1:0];
        quo <= {quo[VALUE_W-2:0], 1'b1};
      end else begin
        rem <= shifted[WIDTH_W-1:0];
        quo <= {quo[VALUE_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + DCW'(1);
    end
    if (cmd.prev_load) prev <= edge_q;
    if (cmd.scan_clr) scan_i <= '0;
    else if (cmd.scan_inc) scan_i <= scan_i + EW'(1);
    if (cmd.bin_set) begin
      case (cmd.bin_src)
        BS_LAST: bin <= BW'(n - EW'(1));
        BS_QUO:  bin <= BW'(quo);
        BS_SCAN: bin <= BW'(scan_i);
        default: bin <= '0;
      endcase
    end
    if (cmd.res_set) begin
      case (cmd.res_kind)
        RK_SLOT: begin
          res_bin <= slot_q[BIN_OUT_W-1:0];
          res_in <= 1'b0;
          res_cnt <= '0;
        end
        RK_READ: begin
          res_bin <= slot_q[BIN_OUT_W-1:0];
          res_in <= 1'b0;
          res_cnt <= (slot_ext < max_ext) ? COUNT_OUT_W'(cnt_q) : '0;
        end
        RK_COUNT: begin
          res_bin <= BIN_OUT_W'(bin);
          res_in <= 1'b1;
          res_cnt <= COUNT_OUT_W'(cnt_new);
        end
        default: begin
          res_bin <= '0;
          res_in <= 1'b0;
          res_cnt <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      bin_found <= res_bin;
      in_range <= res_in;
      count <= res_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_wr && (slot_ext <= max_ext)) edge_mem[EW'(slot_q)] <= value_q;
    if (cmd.edge_rd) edge_q <= edge_mem[edge_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) cnt_mem[clr_addr] <= '0;
    else if (cmd.cnt_wr) cnt_mem[bin] <= cnt_new;
    if (cmd.cnt_rd) cnt_q <= cnt_mem[cnt_addr];
  end

  assign st.clr_last      = (clr_addr == BW'(MAX_BINS - 1));
  assign st.func          = func_q;
  assign st.mode          = spacing_mode;
  assign st.lin_hit_last  = (value_q == last_edge);
  assign st.lin_out       = (value_q < first_edge) || (value_q >= last_edge);
  assign st.div_last      = (div_cnt == DCW'(DIV_STEPS - 1));
  assign st.q_ok          = (quo < VALUE_W'(n));
  assign st.edge_hit_last = (value_q == edge_q);
  assign st.edge_match    = (prev <= value_q) && (value_q < edge_q);
  assign st.scan_last     = (scan_i == n - EW'(1));

endmodule

/* design/hb_checker.sv */
// port-level checks of the histogram binner and their binding
`include "histogram_binner_defines.svh"

module hb_checker import hb_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input logic [BIN_OUT_W-1:0]   result_bin_found,
  input logic                   result_in_range,
  input logic [COUNT_OUT_W-1:0] result_count
);

  logic                                 result_stall;
  logic [BIN_OUT_W+COUNT_OUT_W:0]       result_word;

  assign result_stall = result_valid && !result_ready;
  assign result_word  = {result_bin_found, result_in_range, result_count};

  `HB_ASSERT(a_result_hold, result_stall |=> result_valid && $stable(result_word), "result word changed")
  `HB_ASSERT(a_busy_after_accept, item_valid && item_ready |=> !item_ready, "word taken while busy")
  `HB_ASSERT_RST(a_clear_after_reset, rst |=> !item_ready, "word taken during counter clearing")
  `HB_ASSERT(a_result_from_busy, $rose(result_valid) |-> !$past(item_ready), "result raised while idle")

endmodule

bind histogram_binner hb_checker u_hb_checker (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item.valid),
  .item_ready       (item.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_bin_found (result.bin_found),
  .result_in_range  (result.in_range),
  .result_count     (result.count)
);
